[rtl/msk_pkg.sv]
package msk_pkg;

  // Action codes carried by a request.
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] push_value;
  } msk_in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic [6:0]         entry_count;
    logic               is_empty;
    logic [1:0]         status;
  } msk_out_t;

  // Decoded command handed from the front end to the execution unit.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } msk_cmd_t;

endpackage

[rtl/min_tracking_stack.sv]
// Channel   Direction  Handshake            Payload
// cmd       request    cmd_valid/cmd_stall  msk_in_t  (action, push_value)
// rsp       result     rsp_valid/rsp_stall  msk_out_t (popped, top, min, count, flags)
//
// A request passes a holding register, a two-entry queue and the registered
// result; a pop that leaves entries behind also passes the registered read of
// the new top and its stored minimum.
// Reset clears the count, the top and minimum registers and all valid flags;
// the entry store needs no clearing because only written entries are read.
// A stalled result holds the execution unit, the queue fills and cmd_stall rises.
module min_tracking_stack #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  msk_pkg::msk_in_t  cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output msk_pkg::msk_out_t rsp
);
  import msk_pkg::*;

  // Front end to queue.
  logic     q_push;
  logic     q_full;
  msk_cmd_t q_in;

  // Queue to execution unit.
  logic     q_valid;
  logic     q_pop;
  msk_cmd_t q_head;

  // The front end decodes each request and parks it in its holding register.
  msk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_cmd     (q_in)
  );

  // The queue decouples request acceptance from execution; it holds up to two
  // commands while the execution unit is stalled.
  msk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // The execution unit keeps the top entry and its running minimum in
  // registers and every entry with its own minimum column in memory, which
  // makes a pop of the minimum a single read instead of a rescan.
  msk_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // An empty stack always reports zero for its top and minimum.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |-> rsp.top_value == 32'sd0 && rsp.min_value == 32'sd0)
    else $error("empty stack reports nonzero top or minimum");

  // The tracked minimum can never exceed the value on top.
  a_min_le_top: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.is_empty |-> rsp.min_value <= rsp.top_value)
    else $error("minimum above top of stack");

  // A refused push happens only with the stack at full depth.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_PUSH_FULL |-> rsp.entry_count == 7'(DEPTH))
    else $error("push refused below full depth");

  // A refused pop happens only on an empty stack.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_POP_EMPTY |-> rsp.is_empty)
    else $error("pop refused on a non-empty stack");

  // The front end never writes into a full queue.
  a_queue_overrun: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("queue overrun");

endmodule

[rtl/msk_front.sv]
module msk_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  msk_pkg::msk_in_t  cmd,
  output logic              q_push,
  input  logic              q_full,
  output msk_pkg::msk_cmd_t q_cmd
);
  import msk_pkg::*;

  logic     hold_valid;
  logic     hold_valid_next;
  msk_cmd_t hold;
  logic     accept;

  // The holding register frees up in the same cycle it drains into the queue
  // only if the queue has room, so stall follows the queue being full.
  assign cmd_stall = hold_valid && q_full;
  assign accept    = cmd_valid && !cmd_stall;
  assign q_push    = hold_valid && !q_full;
  assign q_cmd     = hold;

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (q_push) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  // Only a push carries a value; everything else travels with zero data.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold.op    <= cmd.action;
      hold.value <= (cmd.action == ACT_PUSH) ? cmd.push_value : 32'sd0;
    end
  end

endmodule

[rtl/msk_queue.sv]
module msk_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  msk_pkg::msk_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output msk_pkg::msk_cmd_t head
);
  import msk_pkg::*;

  msk_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/msk_back.sv]
module msk_back #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  msk_pkg::msk_cmd_t q_cmd,
  output logic              q_pop,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output msk_pkg::msk_out_t rsp
);
  import msk_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  // Each entry keeps its value and the minimum of itself and everything below.
  typedef struct packed {
    logic signed [31:0] val;
    logic signed [31:0] min;
  } ent_t;

  ent_t mem [DEPTH];
  ent_t rd_ent;

  logic               state;
  logic               state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic signed [31:0] top_val;
  logic signed [31:0] top_val_next;
  logic signed [31:0] top_min;
  logic signed [31:0] top_min_next;
  logic signed [31:0] pend_popped;
  logic signed [31:0] pend_popped_next;
  logic               rsp_valid_next;
  msk_out_t           rsp_next;

  logic               out_free;
  logic               load;
  logic signed [31:0] popped;
  logic [1:0]         status;
  logic signed [31:0] push_min;
  logic               we;
  logic               re;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;

  assign out_free = !rsp_valid || !rsp_stall;
  assign q_pop    = (state == S_IDLE) && q_valid && out_free;
  assign waddr    = count[AW-1:0];
  assign raddr    = AW'(count - CW'(2));
  assign push_min = (count == '0 || q_cmd.value < top_min) ? q_cmd.value : top_min;

  always_comb begin
    state_next       = state;
    count_next       = count;
    top_val_next     = top_val;
    top_min_next     = top_min;
    pend_popped_next = pend_popped;
    load             = 1'b0;
    popped           = 32'sd0;
    status           = ST_OK;
    we               = 1'b0;
    re               = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          case (q_cmd.op)
            ACT_PUSH: begin
              load = 1'b1;
              if (count == CW'(DEPTH)) begin
                status = ST_PUSH_FULL;
              end else begin
                we           = 1'b1;
                count_next   = count + CW'(1);
                top_val_next = q_cmd.value;
                top_min_next = push_min;
              end
            end
            ACT_POP: begin
              if (count == '0) begin
                load   = 1'b1;
                status = ST_POP_EMPTY;
              end else if (count == CW'(1)) begin
                load         = 1'b1;
                popped       = top_val;
                count_next   = '0;
                top_val_next = 32'sd0;
                top_min_next = 32'sd0;
              end else begin
                re               = 1'b1;
                pend_popped_next = top_val;
                count_next       = count - CW'(1);
                state_next       = S_READ;
              end
            end
            ACT_CLEAR: begin
              load         = 1'b1;
              count_next   = '0;
              top_val_next = 32'sd0;
              top_min_next = 32'sd0;
            end
            ACT_QUERY: begin
              load = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        load         = 1'b1;
        popped       = pend_popped;
        top_val_next = rd_ent.val;
        top_min_next = rd_ent.min;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    rsp_next = rsp;
    if (load) begin
      rsp_next.popped_value = popped;
      rsp_next.top_value    = top_val_next;
      rsp_next.min_value    = top_min_next;
      rsp_next.entry_count  = 7'(count_next);
      rsp_next.is_empty     = (count_next == '0);
      rsp_next.status       = status;
    end

    if (load) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      top_val   <= 32'sd0;
      top_min   <= 32'sd0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      top_val   <= top_val_next;
      top_min   <= top_min_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_popped <= pend_popped_next;
    rsp         <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= '{val: q_cmd.value, min: push_min};
    end
    if (re) begin
      rd_ent <= mem[raddr];
    end
  end

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msk_pkg::*;

  localparam int STACK_DEPTH    = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 16;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  msk_in_t  cmd = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  msk_out_t rsp;

  min_tracking_stack #(.DEPTH(STACK_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  // Shadow copy of the stack contents, used to work out each expected result.
  logic signed [31:0] shadow_entries [STACK_DEPTH];
  int                 shadow_fill = 0;
  logic signed [31:0] shadow_min = '0;

  msk_out_t pending_results [$];
  int       error_count = 0;

  // Sender pacing and receiver stall pattern.
  bit       tx_idle_on = 1'b0;
  int       tx_burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       hold_req_count = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       rx_run_left = 0;
  bit       rx_stalling = 1'b0;
  int       quiet_cycles = 0;

  // Applies one request to the shadow stack and returns the result it must produce.
  function automatic msk_out_t predict_stack_result(msk_in_t req);
    msk_out_t           res;
    logic signed [31:0] value;
    logic signed [31:0] popped;
    res    = '0;
    value  = req.push_value;
    popped = '0;
    res.status = ST_OK;
    case (req.action)
      ACT_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          res.status = ST_PUSH_FULL;
        end else begin
          shadow_entries[shadow_fill] = value;
          shadow_fill++;
          if (shadow_fill == 1 || value < shadow_min) shadow_min = value;
        end
      end
      ACT_POP: begin
        if (shadow_fill == 0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          shadow_fill--;
          popped = shadow_entries[shadow_fill];
          if (shadow_fill == 0) begin
            shadow_min = '0;
          end else if (popped == shadow_min) begin
            // The minimum left the stack, so scan what remains.
            shadow_min = shadow_entries[0];
            for (int i = 1; i < shadow_fill; i++)
              if (shadow_entries[i] < shadow_min) shadow_min = shadow_entries[i];
          end
        end
      end
      ACT_CLEAR: begin
        shadow_fill = 0;
        shadow_min  = '0;
      end
      default: ;
    endcase
    res.popped_value = popped;
    if (shadow_fill > 0) begin
      res.top_value = shadow_entries[shadow_fill - 1];
      res.min_value = shadow_min;
    end
    res.entry_count = 7'(shadow_fill);
    res.is_empty    = (shadow_fill == 0);
    return res;
  endfunction

  function automatic msk_in_t make_request(logic [1:0] act, logic signed [31:0] value);
    msk_in_t req;
    req.action     = act;
    req.push_value = value;
    return req;
  endfunction

  function automatic logic signed [31:0] random_value(int kind);
    logic signed [31:0] v;
    case (kind)
      0: v = int'($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = 0;
          3: v = -1;
          4: v = VAL_MIN + 1;
          default: v = $urandom;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offers one request, holds it while stalled, and records its expected result
  // at the edge where it is accepted.
  task automatic send_request(input msk_in_t req);
    int gap;
    if (tx_idle_on) begin
      if (tx_burst_left == 0) begin
        tx_burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          @(negedge clk);
          cmd_valid <= 1'b0;
          cmd <= make_request(2'($urandom), $urandom);
          repeat (gap - 1) @(negedge clk);
        end
      end
      tx_burst_left--;
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd <= req;
    do @(posedge clk); while (cmd_stall);
    pending_results.push_back(predict_stack_result(req));
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: a long hold-off when one is requested, else runs of stall and
  // no stall whose lengths follow the current mode.
  always @(negedge clk) begin
    if (hold_req_count != hold_seen) begin
      hold_seen = hold_req_count;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        case (rx_mode)
          RX_OPEN: begin
            rx_stalling = 1'b0;
            rx_run_left = 8;
          end
          RX_LIGHT: begin
            rx_stalling = ($urandom_range(0, 3) == 0);
            rx_run_left = $urandom_range(1, 4);
          end
          default: begin
            rx_stalling = $urandom_range(0, 1);
            rx_run_left = $urandom_range(1, 12);
          end
        endcase
      end
      rx_run_left--;
      rsp_stall <= rx_stalling;
    end
  end

  function automatic void check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      error_count++;
    end
  endfunction

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    msk_out_t exp_res;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: count %0d status %0d",
               rsp.entry_count, rsp.status);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("popped_value", exp_res.popped_value, rsp.popped_value);
        check_field("top_value", exp_res.top_value, rsp.top_value);
        check_field("min_value", exp_res.min_value, rsp.min_value);
        check_field("entry_count", int'(exp_res.entry_count), int'(rsp.entry_count));
        check_field("is_empty", int'(exp_res.is_empty), int'(rsp.is_empty));
        check_field("status", int'(exp_res.status), int'(rsp.status));
      end
    end
  end

  // Ends the run when work is outstanding but nothing moves for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
          (!cmd_valid && pending_results.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic test_empty_stack();
    rx_mode = RX_OPEN;
    send_request(make_request(ACT_POP, 32'sd0));
    send_request(make_request(ACT_QUERY, 32'sd0));
    send_request(make_request(ACT_CLEAR, VAL_MAX));
    send_request(make_request(ACT_POP, VAL_MIN));
    drain_results();
  endtask

  // Extreme values, a pop of the minimum that forces a rescan, and a pop that
  // empties the stack.
  task automatic test_extreme_values();
    rx_mode = RX_LIGHT;
    send_request(make_request(ACT_PUSH, VAL_MAX));
    send_request(make_request(ACT_PUSH, VAL_MIN));
    send_request(make_request(ACT_PUSH, -32'sd1));
    send_request(make_request(ACT_PUSH, 32'sd0));
    send_request(make_request(ACT_QUERY, VAL_MIN));
    send_request(make_request(ACT_POP, 32'sd0));
    send_request(make_request(ACT_POP, 32'sd0));
    send_request(make_request(ACT_POP, 32'sd0));
    send_request(make_request(ACT_POP, 32'sd0));
    send_request(make_request(ACT_POP, 32'sd0));
    drain_results();
  endtask

  // Two copies of the minimum: popping one must leave the other as minimum.
  task automatic test_repeated_minimum();
    rx_mode = RX_HEAVY;
    send_request(make_request(ACT_PUSH, 32'sd3));
    send_request(make_request(ACT_PUSH, 32'sd3));
    send_request(make_request(ACT_PUSH, 32'sd7));
    send_request(make_request(ACT_POP, 32'sd0));
    send_request(make_request(ACT_POP, 32'sd0));
    send_request(make_request(ACT_QUERY, 32'sd0));
    send_request(make_request(ACT_CLEAR, 32'sd0));
    send_request(make_request(ACT_QUERY, 32'sd0));
    drain_results();
  endtask

  // Fill to capacity, push onto a full stack, then partly empty, refill and
  // empty completely.
  task automatic test_full_stack();
    tx_idle_on = 1'b1;
    rx_mode    = RX_LIGHT;
    for (int i = 0; i < STACK_DEPTH; i++)
      send_request(make_request(ACT_PUSH, random_value(i % 3)));
    send_request(make_request(ACT_PUSH, VAL_MIN));
    send_request(make_request(ACT_PUSH, $urandom));
    for (int i = 0; i < 20; i++) send_request(make_request(ACT_POP, $urandom));
    for (int i = 0; i < 20; i++) send_request(make_request(ACT_PUSH, random_value(0)));
    for (int i = 0; i < STACK_DEPTH; i++) send_request(make_request(ACT_POP, $urandom));
    drain_results();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the
  // block fills and stalls its input.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_mode    = RX_OPEN;
    hold_req_count++;
    for (int i = 0; i < 40; i++)
      send_request(make_request((i % 4 == 3) ? ACT_POP : ACT_PUSH, random_value(i % 3)));
    drain_results();
  endtask

  // Phases that lean toward pushes or pops, with values narrow enough to give
  // repeated minima, full range or near the extremes.
  task automatic test_random_mix(input int num_items);
    int       sent;
    int       phase_len;
    int       push_pct;
    int       value_kind;
    int       roll;
    msk_in_t  req;
    sent = 0;
    while (sent < num_items) begin
      phase_len  = $urandom_range(20, 120);
      push_pct   = (int'($urandom_range(0, 2)) * 25) + 25;
      value_kind = $urandom_range(0, 2);
      tx_idle_on = $urandom_range(0, 2) != 0;
      rx_mode    = rx_mode_t'($urandom_range(0, 2));
      for (int i = 0; i < phase_len && sent < num_items; i++) begin
        roll = $urandom_range(0, 99);
        req.push_value = random_value(value_kind);
        if (roll < 3)
          req.action = ACT_CLEAR;
        else if (roll < 8)
          req.action = ACT_QUERY;
        else if (roll < 8 + (push_pct * 92) / 100)
          req.action = ACT_PUSH;
        else
          req.action = ACT_POP;
        send_request(req);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_stack();
    test_extreme_values();
    test_repeated_minimum();
    test_full_stack();
    test_backpressure();
    test_random_mix(1340);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/msk_pkg.sv
rtl/msk_front.sv
rtl/msk_queue.sv
rtl/msk_back.sv
rtl/min_tracking_stack.sv
dv/tb_top.sv
